@@ src/s5gp_pkg.sv @@
// Shared constants for the SOCKS5 greeting and request parser.
package s5gp_pkg;

  localparam int unsigned StatusW = 4;
  localparam int unsigned KindW   = 2;

  typedef enum logic [StatusW-1:0] {
    ST_MORE      = 4'd0,
    ST_GREET_OK  = 4'd1,
    ST_GREET_BAD = 4'd2,
    ST_NO_METH   = 4'd3,
    ST_REQ_DONE  = 4'd4,
    ST_REQ_BAD   = 4'd5,
    ST_BAD_ATYP  = 4'd6,
    ST_RELAY     = 4'd7,
    ST_CLOSED    = 4'd8
  } status_t;

  typedef enum logic [KindW-1:0] {
    KIND_NONE   = 2'd0,
    KIND_IPV4   = 2'd1,
    KIND_DOMAIN = 2'd2,
    KIND_IPV6   = 2'd3
  } addr_kind_t;

  localparam logic [7:0] SocksVersion = 8'h05;
  localparam logic [7:0] MethodNoAuth = 8'h00;
  localparam logic [7:0] CmdConnect   = 8'h01;
  localparam logic [7:0] RsvZero      = 8'h00;
  localparam logic [7:0] AtypIpv4     = 8'h01;
  localparam logic [7:0] AtypDomain   = 8'h03;
  localparam logic [7:0] AtypIpv6     = 8'h04;
  localparam logic [7:0] LenIpv4      = 8'd4;
  localparam logic [7:0] LenIpv6      = 8'd16;

endpackage

@@ src/socks5_greeting_request_parser.sv @@
// SOCKS5 greeting and CONNECT request parser, one client byte per request.
//
// Input channel: in_valid/in_stall carry byte_in, one client byte per request.
// Output channel: out_valid/out_stall carry one result per input byte: status,
// held address type, length and port, an address-byte flag and the byte echo.
// Output is registered: a byte taken in one cycle appears on the output in
// the next. Throughput is one byte per cycle while the receiver is not
// stalling, as all parse state updates on each accepted byte; a new byte is
// taken while a result waits as long as the receiver is not stalling.
// When the receiver stalls, the result register holds and in_stall rises, so
// no further byte is taken until the result is consumed.
// Reset returns the parser to the start of a greeting with all held address
// fields cleared and the output empty. After a bad request the block answers
// every byte as closed until the next reset.
module socks5_greeting_request_parser (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] byte_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] status,
  output logic [1:0] address_type,
  output logic [7:0] address_length,
  output logic [15:0] dest_port,
  output logic       is_address_byte,
  output logic [7:0] data_out
);

  typedef enum logic [3:0] {
    PH_G_VER, PH_G_NMETH, PH_G_METH,
    PH_R_VER, PH_R_CMD, PH_R_RSV, PH_R_ATYP, PH_R_DLEN, PH_R_ADDR,
    PH_R_PHI, PH_R_PLO, PH_RELAY, PH_CLOSED
  } phase_t;

  phase_t                phase, phase_next;
  logic [7:0]            remaining_count, remaining_count_next;
  logic                  noauth_seen, noauth_seen_next;
  logic                  greeting_error, greeting_error_next;
  s5gp_pkg::addr_kind_t  addr_kind, addr_kind_next;
  logic [7:0]            addr_len_held, addr_len_held_next;
  logic [15:0]           port_held, port_held_next;
  s5gp_pkg::status_t     status_next;
  logic                  is_addr_next;
  logic [7:0]            count_dec;
  logic                  accept;

  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;
  assign count_dec = remaining_count - 8'd1;

  always_comb begin
    phase_next           = phase;
    remaining_count_next = remaining_count;
    noauth_seen_next     = noauth_seen;
    greeting_error_next  = greeting_error;
    addr_kind_next       = addr_kind;
    addr_len_held_next   = addr_len_held;
    port_held_next       = port_held;
    status_next          = s5gp_pkg::ST_MORE;
    is_addr_next         = 1'b0;
    case (phase)
      PH_G_VER: begin
        noauth_seen_next    = 1'b0;
        greeting_error_next = (byte_in != s5gp_pkg::SocksVersion);
        phase_next          = PH_G_NMETH;
      end
      PH_G_NMETH: begin
        if (byte_in == 8'd0) begin
          status_next          = s5gp_pkg::ST_GREET_BAD;
          phase_next           = PH_G_VER;
          remaining_count_next = 8'd0;
          noauth_seen_next     = 1'b0;
          greeting_error_next  = 1'b0;
        end else begin
          remaining_count_next = byte_in;
          phase_next           = PH_G_METH;
        end
      end
      PH_G_METH: begin
        remaining_count_next = count_dec;
        if (byte_in == s5gp_pkg::MethodNoAuth) begin
          noauth_seen_next = 1'b1;
        end
        if (count_dec == 8'd0) begin
          if (greeting_error) begin
            status_next = s5gp_pkg::ST_GREET_BAD;
          end else if (noauth_seen_next) begin
            status_next = s5gp_pkg::ST_GREET_OK;
          end else begin
            status_next = s5gp_pkg::ST_NO_METH;
          end
          if (!greeting_error && noauth_seen_next) begin
            phase_next         = PH_R_VER;
            addr_kind_next     = s5gp_pkg::KIND_NONE;
            addr_len_held_next = 8'd0;
            port_held_next     = 16'd0;
          end else begin
            phase_next           = PH_G_VER;
            remaining_count_next = 8'd0;
            noauth_seen_next     = 1'b0;
            greeting_error_next  = 1'b0;
          end
        end
      end
      PH_R_VER: begin
        if (byte_in != s5gp_pkg::SocksVersion) begin
          status_next = s5gp_pkg::ST_REQ_BAD;
          phase_next  = PH_CLOSED;
        end else begin
          phase_next = PH_R_CMD;
        end
      end
      PH_R_CMD: begin
        if (byte_in != s5gp_pkg::CmdConnect) begin
          status_next = s5gp_pkg::ST_REQ_BAD;
          phase_next  = PH_CLOSED;
        end else begin
          phase_next = PH_R_RSV;
        end
      end
      PH_R_RSV: begin
        if (byte_in != s5gp_pkg::RsvZero) begin
          status_next = s5gp_pkg::ST_REQ_BAD;
          phase_next  = PH_CLOSED;
        end else begin
          phase_next = PH_R_ATYP;
        end
      end
      PH_R_ATYP: begin
        if (byte_in == s5gp_pkg::AtypIpv4) begin
          addr_kind_next       = s5gp_pkg::KIND_IPV4;
          addr_len_held_next   = s5gp_pkg::LenIpv4;
          remaining_count_next = s5gp_pkg::LenIpv4;
          phase_next           = PH_R_ADDR;
        end else if (byte_in == s5gp_pkg::AtypDomain) begin
          addr_kind_next = s5gp_pkg::KIND_DOMAIN;
          phase_next     = PH_R_DLEN;
        end else if (byte_in == s5gp_pkg::AtypIpv6) begin
          addr_kind_next       = s5gp_pkg::KIND_IPV6;
          addr_len_held_next   = s5gp_pkg::LenIpv6;
          remaining_count_next = s5gp_pkg::LenIpv6;
          phase_next           = PH_R_ADDR;
        end else begin
          status_next = s5gp_pkg::ST_BAD_ATYP;
          phase_next  = PH_CLOSED;
        end
      end
      PH_R_DLEN: begin
        addr_len_held_next   = byte_in;
        remaining_count_next = byte_in;
        phase_next           = (byte_in == 8'd0) ? PH_R_PHI : PH_R_ADDR;
      end
      PH_R_ADDR: begin
        is_addr_next         = 1'b1;
        remaining_count_next = count_dec;
        if (count_dec == 8'd0) begin
          phase_next = PH_R_PHI;
        end
      end
      PH_R_PHI: begin
        port_held_next = {byte_in, 8'd0};
        phase_next     = PH_R_PLO;
      end
      PH_R_PLO: begin
        port_held_next = {port_held[15:8], byte_in};
        status_next    = s5gp_pkg::ST_REQ_DONE;
        phase_next     = PH_RELAY;
      end
      PH_RELAY: begin
        status_next = s5gp_pkg::ST_RELAY;
      end
      default: begin
        status_next = s5gp_pkg::ST_CLOSED;
        phase_next  = PH_CLOSED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_G_VER;
      remaining_count <= 8'd0;
      noauth_seen     <= 1'b0;
      greeting_error  <= 1'b0;
      addr_kind       <= s5gp_pkg::KIND_NONE;
      addr_len_held   <= 8'd0;
      port_held       <= 16'd0;
      out_valid       <= 1'b0;
      status          <= s5gp_pkg::ST_MORE;
      address_type    <= s5gp_pkg::KIND_NONE;
      address_length  <= 8'd0;
      dest_port       <= 16'd0;
      is_address_byte <= 1'b0;
      data_out        <= 8'd0;
    end else begin
      if (accept) begin
        phase           <= phase_next;
        remaining_count <= remaining_count_next;
        noauth_seen     <= noauth_seen_next;
        greeting_error  <= greeting_error_next;
        addr_kind       <= addr_kind_next;
        addr_len_held   <= addr_len_held_next;
        port_held       <= port_held_next;
        out_valid       <= 1'b1;
        status          <= status_next;
        address_type    <= addr_kind_next;
        address_length  <= addr_len_held_next;
        dest_port       <= port_held_next;
        is_address_byte <= is_addr_next;
        data_out        <= byte_in;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
